FILE: hw/rtl/ipr_pkg.sv
// Package with shared types, constants and status codes for the IP reassembly tracker.
package ipr_pkg;

  // Default table size and register reset value.
  localparam int SLOTS_DEFAULT = 8;
  localparam logic [15:0] LIFETIME_RESET = 16'd30;

  // Byte counts saturate at this value.
  localparam logic [16:0] LEN_MAX = 17'h1FFFF;

  // Result status codes.
  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_TICK     = 2'd3;

  // Input item modes.
  localparam logic MODE_FRAG = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One input word.
  typedef struct packed {
    logic        mode;
    logic [15:0] frag_id;
    logic        more_frags;
    logic [12:0] frag_offset;
    logic [15:0] payload_len;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [16:0] datagram_len;
    logic [7:0]  expired_mask;
  } result_t;

endpackage

FILE: hw/rtl/ip_reassembly_tracker_top.sv
// Top level of the IPv4 fragment reassembly tracker: slot table and its sequencer.
// Fragment: the slot scan reads one entry per cycle until an ID match or the last slot, then
// S_ADD_RX, S_ADD_TOT and S_FIN lead to the result strobe; with no match and no free slot it is dropped.
// Tick: one age compare per slot per cycle; the result is registered at the last slot.
// busy stays high from accept until the result strobe; one word at a time.
// Synchronous reset frees every slot, clears time and sets lifetime to 30.
module ip_reassembly_tracker_top #(
  parameter int SLOTS = ipr_pkg::SLOTS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ipr_pkg::cmd_t    cmd,
  output logic             done,
  output ipr_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ADD_RX,
    S_ADD_TOT,
    S_FIN,
    S_TICK
  } state_t;

  state_t state;

  // Slot table, accessed at the scan index or the chosen slot only.
  logic        tbl_valid [SLOTS];
  logic [15:0] tbl_id    [SLOTS];
  logic [16:0] tbl_rx    [SLOTS];
  logic [16:0] tbl_exp   [SLOTS];
  logic        tbl_known [SLOTS];
  logic [31:0] tbl_start [SLOTS];

  // Working registers of the sequencer.
  ipr_pkg::cmd_t  req;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] hit;
  logic [IDX_W-1:0] free_idx;
  logic             free_found;
  logic             new_slot;
  logic [16:0]      rx;
  logic [16:0]      expb;
  logic             known;
  logic [7:0]       mask;
  logic [31:0]      now_ticks;
  logic [15:0]      lifetime;

  logic [16:0] add_a;
  logic [16:0] add_b;
  logic [16:0] add_sum;
  logic [31:0] age;
  logic        id_match;
  logic        expired;
  logic        complete;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Operand select for the shared adder: received count first, then total length.
  always_comb begin
    case (state)
      S_ADD_TOT: add_a = {1'b0, req.frag_offset, 3'b000};
      default:   add_a = rx;
    endcase
  end
  assign add_b = {1'b0, req.payload_len};

  ipr_sat_add u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  // Per-entry checks at the scan index.
  assign id_match = tbl_valid[idx] && (tbl_id[idx] == req.frag_id);
  assign age      = now_ticks - tbl_start[idx];
  assign expired  = tbl_valid[idx] && (age > {16'b0, lifetime});
  assign complete = known && (rx == expb);

  // Sequencer, table and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      now_ticks  <= '0;
      lifetime   <= ipr_pkg::LIFETIME_RESET;
      idx        <= '0;
      free_found <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        tbl_valid[k] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        lifetime <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req        <= cmd;
            idx        <= '0;
            free_found <= 1'b0;
            mask       <= '0;
            if (cmd.mode == ipr_pkg::MODE_TICK) begin
              now_ticks <= now_ticks + 32'd1;
              state     <= S_TICK;
            end else begin
              state <= S_LOOK;
            end
          end
        end

        // Scan for a matching ID, remembering the lowest free slot.
        S_LOOK: begin
          if (!tbl_valid[idx] && !free_found) begin
            free_idx   <= idx;
            free_found <= 1'b1;
          end
          if (id_match) begin
            hit      <= idx;
            new_slot <= 1'b0;
            rx       <= tbl_rx[idx];
            expb     <= tbl_exp[idx];
            known    <= tbl_known[idx];
            state    <= S_ADD_RX;
          end else if (idx == LAST_IDX) begin
            if (free_found || !tbl_valid[idx]) begin
              hit      <= free_found ? free_idx : idx;
              new_slot <= 1'b1;
              rx       <= '0;
              expb     <= '0;
              known    <= 1'b0;
              state    <= S_ADD_RX;
            end else begin
              result.status       <= ipr_pkg::ST_DROPPED;
              result.slot         <= '0;
              result.datagram_len <= '0;
              result.expired_mask <= '0;
              done                <= 1'b1;
              state               <= S_IDLE;
            end
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        S_ADD_RX: begin
          rx    <= add_sum;
          state <= S_ADD_TOT;
        end

        // A last fragment fixes the total length.
        S_ADD_TOT: begin
          if (!req.more_frags) begin
            expb  <= add_sum;
            known <= 1'b1;
          end
          state <= S_FIN;
        end

        // Write the entry back and report.
        S_FIN: begin
          tbl_valid[hit] <= !complete;
          tbl_id[hit]    <= req.frag_id;
          tbl_rx[hit]    <= rx;
          tbl_exp[hit]   <= expb;
          tbl_known[hit] <= known;
          if (new_slot) begin
            tbl_start[hit] <= now_ticks;
          end
          result.status       <= complete ? ipr_pkg::ST_COMPLETE : ipr_pkg::ST_PENDING;
          result.slot         <= 3'(hit);
          result.datagram_len <= complete ? expb : '0;
          result.expired_mask <= '0;
          done                <= 1'b1;
          state               <= S_IDLE;
        end

        // Timeout sweep, one slot per cycle.
        S_TICK: begin
          if (expired) begin
            tbl_valid[idx] <= 1'b0;
            mask[idx]      <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            result.status       <= ipr_pkg::ST_TICK;
            result.slot         <= '0;
            result.datagram_len <= '0;
            result.expired_mask <= expired ? (mask | (8'd1 << idx)) : mask;
            done                <= 1'b1;
            state               <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/ipr_sat_add.sv
// Shared saturating length adder used for byte counts and total lengths.
module ipr_sat_add (
  input  logic [16:0] a,
  input  logic [16:0] b,
  output logic [16:0] sum
);

  logic [17:0] full;

  // Add with one carry bit; any carry means the 17-bit range was exceeded.
  assign full = {1'b0, a} + {1'b0, b};
  assign sum  = full[17] ? ipr_pkg::LEN_MAX : full[16:0];

endmodule

FILE: hw/rtl/ipr_checker.sv
// Port-level checker for the IP reassembly tracker, bound to the top level.
module ipr_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input ipr_pkg::result_t result
);

  // A result word only appears once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted word always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Only tick results carry an expiry mask.
  a_mask_tick: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ipr_pkg::ST_TICK) |-> (result.expired_mask == 8'd0))
    else $error("expiry mask on a fragment result");

  // A length is reported only with a completed datagram.
  a_len_complete: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ipr_pkg::ST_COMPLETE) |-> (result.datagram_len == 17'd0))
    else $error("length on a result that is not complete");

  // Drops and ticks name no slot.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ipr_pkg::ST_DROPPED || result.status == ipr_pkg::ST_TICK))
      |-> (result.slot == 3'd0))
    else $error("slot set on a drop or tick result");

endmodule

bind ip_reassembly_tracker_top ipr_checker u_ipr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

FILE: verif/testbench.sv
// Self-checking testbench for the IPv4 fragment reassembly tracker, with its table predictor.
`timescale 1ns / 100ps

// Predicts the result of each accepted word and checks the results that come back.
class reassembly_scoreboard;
  localparam int NSLOTS = ipr_pkg::SLOTS_DEFAULT;

  // Shadow copy of the reassembly table, the tick counter and the register.
  logic        entry_valid [NSLOTS];
  logic [15:0] entry_id [NSLOTS];
  logic [16:0] entry_rcvd [NSLOTS];
  logic [16:0] entry_total [NSLOTS];
  logic        entry_total_known [NSLOTS];
  logic [31:0] entry_opened [NSLOTS];
  logic [31:0] tick_count;
  logic [15:0] lifetime;

  ipr_pkg::result_t expected_results [$];
  int               mismatches;

  function new();
    for (int k = 0; k < NSLOTS; k++) free_entry(k);
    tick_count = '0;
    lifetime = ipr_pkg::LIFETIME_RESET;
    mismatches = 0;
  endfunction

  function void free_entry(int k);
    entry_valid[k] = 1'b0;
    entry_id[k] = '0;
    entry_rcvd[k] = '0;
    entry_total[k] = '0;
    entry_total_known[k] = 1'b0;
    entry_opened[k] = '0;
  endfunction

  function void set_lifetime(logic [15:0] value);
    lifetime = value;
  endfunction

  // Works out the result of one accepted word and queues it.
  function void note_command(ipr_pkg::cmd_t c);
    ipr_pkg::result_t r;
    int hit;
    logic [17:0] sum;
    logic [17:0] total;
    r = '0;
    hit = -1;
    if (c.mode == ipr_pkg::MODE_TICK) begin
      // Time moves first, then every entry older than the lifetime is freed.
      tick_count = tick_count + 32'd1;
      for (int k = 0; k < NSLOTS; k++) begin
        if (entry_valid[k] && (tick_count - entry_opened[k]) > {16'd0, lifetime}) begin
          free_entry(k);
          r.expired_mask[k] = 1'b1;
        end
      end
      r.status = ipr_pkg::ST_TICK;
      expected_results.push_back(r);
      return;
    end
    // Lowest valid entry with a matching ID wins.
    for (int k = 0; k < NSLOTS; k++) begin
      if (hit < 0 && entry_valid[k] && entry_id[k] == c.frag_id) hit = k;
    end
    // Otherwise open the lowest free entry, or drop the fragment.
    if (hit < 0) begin
      for (int k = 0; k < NSLOTS; k++) begin
        if (hit < 0 && !entry_valid[k]) hit = k;
      end
      if (hit < 0) begin
        r.status = ipr_pkg::ST_DROPPED;
        expected_results.push_back(r);
        return;
      end
      free_entry(hit);
      entry_valid[hit] = 1'b1;
      entry_id[hit] = c.frag_id;
      entry_opened[hit] = tick_count;
    end
    // Byte counts saturate; a last fragment fixes (or replaces) the total.
    sum = entry_rcvd[hit] + c.payload_len;
    entry_rcvd[hit] = (sum > ipr_pkg::LEN_MAX) ? ipr_pkg::LEN_MAX : sum[16:0];
    if (!c.more_frags) begin
      total = {c.frag_offset, 3'b000} + c.payload_len;
      entry_total[hit] = (total > ipr_pkg::LEN_MAX) ? ipr_pkg::LEN_MAX : total[16:0];
      entry_total_known[hit] = 1'b1;
    end
    r.slot = hit[2:0];
    r.status = ipr_pkg::ST_PENDING;
    if (entry_total_known[hit] && entry_rcvd[hit] == entry_total[hit]) begin
      r.status = ipr_pkg::ST_COMPLETE;
      r.datagram_len = entry_total[hit];
      free_entry(hit);
    end
    expected_results.push_back(r);
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Compares one result word with the oldest expectation, field by field.
  task check_result(ipr_pkg::result_t got);
    ipr_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
    if (got.slot !== want.slot)
      report_mismatch($sformatf("slot %0d, predicted %0d", got.slot, want.slot));
    if (got.datagram_len !== want.datagram_len)
      report_mismatch($sformatf("datagram_len %0d, predicted %0d",
                                got.datagram_len, want.datagram_len));
    if (got.expired_mask !== want.expired_mask)
      report_mismatch($sformatf("expired_mask %h, predicted %h",
                                got.expired_mask, want.expired_mask));
  endtask
endclass

module testbench;
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  ipr_pkg::cmd_t    cmd = '0;
  logic             cfg_valid = 1'b0;
  logic [15:0]      cfg_data = '0;
  logic             busy;
  logic             done;
  logic             cfg_ready;
  ipr_pkg::result_t result;

  reassembly_scoreboard tracker_check;

  // Fragments of planned datagrams, interleaved and reordered at random.
  ipr_pkg::cmd_t frag_backlog [$];
  int            issued = 0;
  int            quiet_from = 800;
  int            quiet_to = 1150;

  ip_reassembly_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both sides of the block at every rising edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) tracker_check.note_command(cmd);
    if (!rst && done) tracker_check.check_result(result);
  end

  function automatic ipr_pkg::cmd_t make_frag(logic [15:0] id, logic more, logic [12:0] off,
                                              logic [15:0] len);
    ipr_pkg::cmd_t c;
    c.mode = ipr_pkg::MODE_FRAG;
    c.frag_id = id;
    c.more_frags = more;
    c.frag_offset = off;
    c.payload_len = len;
    return c;
  endfunction

  // Sends one word; outside the quiet stretch start drops at random cycles.
  task automatic send_word(input ipr_pkg::cmd_t c);
    logic idle;
    cmd <= c;
    forever begin
      idle = (issued < quiet_from || issued >= quiet_to) && ($urandom_range(99) < 30);
      start <= !idle;
      @(posedge clk);
      if (!idle && !busy) break;
    end
    issued++;
  endtask

  // Writes the lifetime register once the block has drained.
  task automatic write_lifetime(input logic [15:0] value);
    start <= 1'b0;
    while (tracker_check.expected_results.size() != 0) @(posedge clk);
    repeat (ipr_pkg::SLOTS_DEFAULT + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker_check.set_lifetime(value);
  endtask

  // Plans one well-formed datagram and scatters its fragments into the backlog.
  task automatic plan_datagram();
    logic [15:0]   id;
    int            nfrag;
    int            units;
    int            len;
    bit            big;
    ipr_pkg::cmd_t c;
    id = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
    nfrag = $urandom_range(4, 1);
    big = ($urandom_range(29) == 0);
    units = 0;
    for (int i = 0; i < nfrag; i++) begin
      if (i == nfrag - 1) begin
        len = $urandom_range(big ? 65515 : 300);
        c = make_frag(id, 1'b0, 13'(units), 16'(len));
      end else begin
        len = 8 * $urandom_range(big ? 2000 : 40);
        c = make_frag(id, 1'b1, 13'(units), 16'(len));
        units += len / 8;
      end
      frag_backlog.insert($urandom_range(frag_backlog.size()), c);
    end
  endtask

  // Random mix: mostly datagram fragments, plus ticks, noise and lost fragments.
  task automatic run_phase(int count, int tick_pct);
    ipr_pkg::cmd_t c;
    int            roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < tick_pct) begin
        c.mode = ipr_pkg::MODE_TICK;
        c.frag_id = 16'($urandom);
        c.more_frags = 1'($urandom);
        c.frag_offset = 13'($urandom);
        c.payload_len = 16'($urandom_range(65515));
      end else if (roll < tick_pct + 8) begin
        c = make_frag(($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
                      1'($urandom),
                      ($urandom_range(1) == 0) ? 13'd0 : 13'($urandom),
                      16'($urandom_range(65515)));
      end else begin
        if (frag_backlog.size() < 4) plan_datagram();
        // Now and then a fragment is lost, so its datagram must time out.
        if ($urandom_range(99) < 3) void'(frag_backlog.pop_front());
        if (frag_backlog.size() == 0) plan_datagram();
        c = frag_backlog.pop_front();
      end
      send_word(c);
    end
  endtask

  initial begin
    ipr_pkg::cmd_t c;
    int            drain;
    logic [15:0]   lifetimes [5];
    tracker_check = new();
    lifetimes[0] = 16'd0;
    lifetimes[1] = 16'd65535;
    lifetimes[2] = 16'd1;
    lifetimes[3] = 16'($urandom_range(40, 2));
    lifetimes[4] = 16'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero-length datagram under ID 0, which must still be a real ID.
    send_word(make_frag(16'h0000, 1'b0, 13'd0, 16'd0));
    // Largest fragments: saturate the byte count, then overshoot the total.
    send_word(make_frag(16'hFFFF, 1'b1, 13'd0, 16'd65515));
    send_word(make_frag(16'hFFFF, 1'b1, 13'd8191, 16'd65515));
    send_word(make_frag(16'hFFFF, 1'b1, 13'd100, 16'd65515));
    send_word(make_frag(16'hFFFF, 1'b0, 13'd8191, 16'd65515));
    // A repeated last fragment replaces the total and completes the datagram.
    send_word(make_frag(16'h1234, 1'b0, 13'd4, 16'd8));
    send_word(make_frag(16'h1234, 1'b0, 13'd1, 16'd8));
    // Last fragment first, then the head.
    send_word(make_frag(16'hABCD, 1'b0, 13'd2, 16'd5));
    send_word(make_frag(16'hABCD, 1'b1, 13'd0, 16'd16));
    // Fill every free entry, one with the largest offset, then overflow the table.
    for (int i = 0; i < 6; i++) send_word(make_frag(16'h0100 + 16'(i), 1'b1, 13'd0, 16'd8));
    send_word(make_frag(16'h5555, 1'b0, 13'd8191, 16'd0));
    send_word(make_frag(16'h0200, 1'b1, 13'd0, 16'd8));
    // Tick with every ignored field set.
    c = '1;
    c.payload_len = 16'd65515;
    send_word(c);

    // Random phases: reset lifetime first, then each written setting.
    run_phase(330, 15);
    for (int p = 0; p < 5; p++) begin
      write_lifetime(lifetimes[p]);
      run_phase(315, 15);
    end

    // Drain, then allow for the longest latency.
    start <= 1'b0;
    drain = 0;
    while (tracker_check.expected_results.size() != 0 && drain < 200) begin
      @(posedge clk);
      drain++;
    end
    repeat (ipr_pkg::SLOTS_DEFAULT + 4) @(posedge clk);
    if (tracker_check.expected_results.size() != 0)
      tracker_check.report_mismatch($sformatf("%0d result words never arrived",
                                              tracker_check.expected_results.size()));
    if (tracker_check.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
